// ----- hdl/svs_pkg.sv -----
package svs_pkg;

  // Element and vector limits.
  localparam int VALUE_BITS = 10;
  localparam int MAX_LEN    = 4096;
  localparam int MAP_DEPTH  = 1 << VALUE_BITS;

  // Accumulator widths.
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 22;
  localparam int SQS_W   = 31;
  localparam int CNTR_W  = 12;
  localparam int PROD_W  = CNT_W + SQS_W;
  localparam int NN_W    = 2 * CNT_W;
  localparam int EPOCH_W = 8;

  // Shared divider and square root unit widths.
  localparam int DIV_NUM_W = PROD_W + 16;
  localparam int DIV_DEN_W = NN_W;
  localparam int SQRT_W    = 36;
  localparam int ROOT_W    = SQRT_W / 2;

  // Result field widths.
  localparam int AMP_W  = 11;
  localparam int Q8_W   = 18;
  localparam int DIS_W  = 17;
  localparam int DENS_W = 16;
  localparam int TAG_W  = 16;

  // Quotient selection for the shared divider.
  typedef enum logic [1:0] {
    OP_MEAN,
    OP_VAR,
    OP_DIS,
    OP_DENS
  } div_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_step;
    logic    accept;
    logic    update;
    logic    mul;
    logic    var_sub;
    logic    div_start;
    div_op_e div_op;
    logic    div_capture;
    logic    sqrt_start;
    logic    sqrt_capture;
    logic    load;
  } svs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_elem;
    logic epoch_wrap;
    logic clear_last;
    logic div_done;
    logic sqrt_done;
  } svs_status_t;

endpackage

// ----- hdl/svs_if.sv -----
interface svs_in_if
  import svs_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;
  logic                         last_element;
  logic [TAG_W-1:0]             vector_tag;

  modport source (output valid, element_value, last_element, vector_tag, input ready);
  modport sink   (input valid, element_value, last_element, vector_tag, output ready);
endinterface

interface svs_out_if
  import svs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CNT_W-1:0]       element_count;
  logic [AMP_W-1:0]       amplitude;
  logic signed [Q8_W-1:0] mean_q8;
  logic [Q8_W-1:0]        std_dev_q8;
  logic [DIS_W-1:0]       disorder_q16;
  logic [CNTR_W-1:0]      repetition_count;
  logic [DENS_W-1:0]      duplicate_density_q16;
  logic [TAG_W-1:0]       result_tag;

  modport source (output valid, element_count, amplitude, mean_q8, std_dev_q8,
                  disorder_q16, repetition_count, duplicate_density_q16, result_tag,
                  input ready);
  modport sink   (input valid, element_count, amplitude, mean_q8, std_dev_q8,
                  disorder_q16, repetition_count, duplicate_density_q16, result_tag,
                  output ready);
endinterface

// ----- hdl/svs_div.sv -----
module svs_div
  import svs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  localparam int CNT_BITS = $clog2(DIV_NUM_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [DIV_NUM_W-1:0] sh_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_q;
  logic [DIV_DEN_W:0]   rem_t;
  logic                 fits;

  // One restoring step: bring down the next numerator bit and try to subtract.
  always_comb begin
    rem_t = {rem_q[DIV_DEN_W-1:0], sh_q[DIV_NUM_W-1]};
    fits  = rem_t >= {1'b0, den_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and the shifting numerator that turns into the quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[DIV_NUM_W-2:0], fits};
      rem_q <= fits ? (rem_t - {1'b0, den_q}) : rem_t;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ----- hdl/svs_sqrt.sv -----
module svs_sqrt
  import svs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQRT_W-1:0] rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [SQRT_W-1:0] TOP_BIT = SQRT_W'(1) << (SQRT_W - 2);

  logic              busy_q;
  logic              done_q;
  logic [SQRT_W-1:0] x_q;
  logic [SQRT_W-1:0] r_q;
  logic [SQRT_W-1:0] bit_q;
  logic [SQRT_W-1:0] trial;
  logic              fits;

  // Digit-by-digit root: two radicand bits per cycle.
  always_comb begin
    trial = r_q + bit_q;
    fits  = x_q >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= rad_i;
      r_q   <= '0;
      bit_q <= TOP_BIT;
    end else if (busy_q) begin
      if (fits) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

// ----- hdl/svs_ctrl.sv -----
module svs_ctrl
  import svs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  svs_status_t status_i,
  output svs_cmd_t    cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_UPDATE = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_VAR    = 4'd4;
  localparam logic [3:0] S_DGO    = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_SGO    = 4'd7;
  localparam logic [3:0] S_SWAIT  = 4'd8;
  localparam logic [3:0] S_LOAD   = 4'd9;

  logic [3:0] state_q, state_d;
  div_op_e    op_q, op_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.div_op = op_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.final_elem) begin
          state_d = S_MUL;
          op_d    = OP_MEAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_VAR;
      end
      S_VAR: begin
        cmd_o.var_sub = 1'b1;
        state_d       = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          case (op_q)
            OP_MEAN: begin
              op_d    = OP_VAR;
              state_d = S_DGO;
            end
            OP_VAR:  state_d = S_SGO;
            OP_DIS: begin
              op_d    = OP_DENS;
              state_d = S_DGO;
            end
            default: state_d = S_LOAD;
          endcase
        end
      end
      S_SGO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SWAIT;
      end
      S_SWAIT: begin
        if (status_i.sqrt_done) begin
          cmd_o.sqrt_capture = 1'b1;
          op_d               = OP_DIS;
          state_d            = S_DGO;
        end
      end
      S_LOAD: begin
        // Hand over only once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = status_i.epoch_wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_MEAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/svs_datapath.sv -----
module svs_datapath
  import svs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  svs_cmd_t                     cmd_i,
  output svs_status_t                  status_o,
  input  logic signed [VALUE_BITS-1:0] element_value_i,
  input  logic                         last_element_i,
  input  logic [TAG_W-1:0]             vector_tag_i,
  output logic [CNT_W-1:0]             element_count_o,
  output logic [AMP_W-1:0]             amplitude_o,
  output logic signed [Q8_W-1:0]       mean_q8_o,
  output logic [Q8_W-1:0]              std_dev_q8_o,
  output logic [DIS_W-1:0]             disorder_q16_o,
  output logic [CNTR_W-1:0]            repetition_count_o,
  output logic [DENS_W-1:0]            duplicate_density_q16_o,
  output logic [TAG_W-1:0]             result_tag_o
);

  // Seen-value map: each entry holds the epoch of the vector that last wrote it.
  logic [EPOCH_W-1:0]    map_mem [MAP_DEPTH];
  logic [EPOCH_W-1:0]    map_rd_q;
  logic [EPOCH_W-1:0]    epoch_q;
  logic [VALUE_BITS-1:0] clr_addr_q;

  // Captured transaction.
  logic signed [VALUE_BITS-1:0] val_q;
  logic                         last_q;
  logic [TAG_W-1:0]             tag_q;

  // Per-vector accumulators.
  logic [CNT_W-1:0]             cnt_q;
  logic signed [VALUE_BITS-1:0] min_q, max_q, prev_q;
  logic signed [SUM_W-1:0]      sum_q;
  logic [SQS_W-1:0]             sqs_q;
  logic [CNTR_W-1:0]            desc_q, rep_q;

  // End-of-vector intermediates.
  logic [PROD_W-1:0] prod_a_q, prod_b_q, varnum_q;
  logic [NN_W-1:0]   nn_q;
  logic [Q8_W-1:0]   mean_q;
  logic [SQRT_W-1:0] rad_q;
  logic [Q8_W-1:0]   std_q;
  logic [DIS_W-1:0]  dis_q;
  logic [DENS_W-1:0] dens_q;

  logic                         first;
  logic                         seen;
  logic signed [2*VALUE_BITS-1:0] sq_v;
  logic [SUM_W-1:0]             abs_sum;
  logic [DIV_NUM_W-1:0]         div_num;
  logic [DIV_DEN_W-1:0]         div_den;
  logic                         div_done;
  logic [DIV_NUM_W-1:0]         quo;
  logic                         sqrt_done;
  logic [ROOT_W-1:0]            root;
  logic [Q8_W-1:0]              q18;

  always_comb begin
    first   = cnt_q == '0;
    seen    = map_rd_q == epoch_q;
    sq_v    = val_q * val_q;
    abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    q18     = quo[Q8_W-1:0];
  end

  // Status toward the controller.
  always_comb begin
    status_o.final_elem = last_q || (cnt_q == CNT_W'(MAX_LEN - 1));
    status_o.epoch_wrap = epoch_q == '0;
    status_o.clear_last = clr_addr_q == '1;
    status_o.div_done   = div_done;
    status_o.sqrt_done  = sqrt_done;
  end

  // Map memory: one write and one registered read per cycle. Reads and update
  // writes use the raw bit pattern of the element; clearing writes use the pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      map_mem[clr_addr_q] <= '0;
    end else if (cmd_i.update) begin
      map_mem[unsigned'(val_q)] <= epoch_q;
    end
    map_rd_q <= map_mem[unsigned'(element_value_i)];
  end

  // Clearing pointer and epoch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      epoch_q    <= '0;
    end else if (cmd_i.clear_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      epoch_q    <= EPOCH_W'(1);
    end else if (cmd_i.update && status_o.final_elem) begin
      epoch_q <= epoch_q + 1'b1;
    end
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      val_q  <= element_value_i;
      last_q <= last_element_i;
      tag_q  <= vector_tag_i;
    end
  end

  // Running statistics, cleared when the result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      prev_q <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
      desc_q <= '0;
      rep_q  <= '0;
    end else if (cmd_i.load) begin
      cnt_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      prev_q <= '0;
      sum_q  <= '0;
      sqs_q  <= '0;
      desc_q <= '0;
      rep_q  <= '0;
    end else if (cmd_i.update) begin
      if (first || val_q < min_q) begin
        min_q <= val_q;
      end
      if (first || val_q > max_q) begin
        max_q <= val_q;
      end
      if (!first && prev_q > val_q) begin
        desc_q <= desc_q + 1'b1;
      end
      if (seen) begin
        rep_q <= rep_q + 1'b1;
      end
      prev_q <= val_q;
      sum_q  <= sum_q + SUM_W'(val_q);
      sqs_q  <= sqs_q + SQS_W'(unsigned'(sq_v));
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // Products and the variance numerator, each step registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_a_q <= PROD_W'(cnt_q) * PROD_W'(sqs_q);
      prod_b_q <= PROD_W'(abs_sum) * PROD_W'(abs_sum);
      nn_q     <= NN_W'(cnt_q) * NN_W'(cnt_q);
    end
    if (cmd_i.var_sub) begin
      varnum_q <= prod_a_q - prod_b_q;
    end
  end

  // Operands of the shared divider.
  always_comb begin
    case (cmd_i.div_op)
      OP_MEAN: begin
        div_num = DIV_NUM_W'({abs_sum, 8'd0});
        div_den = DIV_DEN_W'(cnt_q);
      end
      OP_VAR: begin
        div_num = {varnum_q, 16'd0};
        div_den = nn_q;
      end
      OP_DIS: begin
        div_num = DIV_NUM_W'({desc_q, 16'd0});
        div_den = DIV_DEN_W'(cnt_q - 1'b1);
      end
      default: begin
        div_num = DIV_NUM_W'({rep_q, 16'd0});
        div_den = DIV_DEN_W'(cnt_q);
      end
    endcase
  end

  svs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  svs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (rad_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Quotient and root capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      case (cmd_i.div_op)
        OP_MEAN: mean_q <= sum_q[SUM_W-1] ? Q8_W'(-q18) : q18;
        OP_VAR:  rad_q  <= quo[SQRT_W-1:0];
        OP_DIS:  dis_q  <= (cnt_q > CNT_W'(1)) ? quo[DIS_W-1:0] : '0;
        default: dens_q <= quo[DENS_W-1:0];
      endcase
    end
    if (cmd_i.sqrt_capture) begin
      std_q <= Q8_W'(root);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      element_count_o         <= cnt_q;
      amplitude_o             <= AMP_W'(AMP_W'(max_q) - AMP_W'(min_q) + 1'b1);
      mean_q8_o               <= mean_q;
      std_dev_q8_o            <= std_q;
      disorder_q16_o          <= dis_q;
      repetition_count_o      <= rep_q;
      duplicate_density_q16_o <= dens_q;
      result_tag_o            <= tag_q;
    end
  end

endmodule

// ----- hdl/streaming_vector_statistics_core.sv -----
// Streaming vector statistics.
// The input channel takes one signed element per transaction with a last flag
// and a vector tag. A vector also ends at its 4096th element. After the last
// element the output channel gives one transaction: the count, the amplitude,
// the mean and standard deviation in Q8, the descent ratio and repeat density
// in Q16, the repeat count and the tag of the last element.
// Each element takes a map read and then an update. The end of a vector then
// runs the product and variance subtraction steps, four divisions on one shared
// bit-serial divider and a square root. No element is taken while they run.
// The result waits in an output register; the next vector streams in while a
// stalled receiver holds it, and the next result waits until it is taken.
// Reset clears all counters and starts a clearing pass over the 1024 entries
// of the seen-value map, with the input not ready. The map is marked by vector
// epoch, so the same pass runs again after every 255 vectors.
module streaming_vector_statistics_core
  import svs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  svs_in_if.sink    in_i,
  svs_out_if.source out_o
);

  svs_cmd_t    cmd;
  svs_status_t status;

  svs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  svs_datapath u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .status_o                (status),
    .element_value_i         (in_i.element_value),
    .last_element_i          (in_i.last_element),
    .vector_tag_i            (in_i.vector_tag),
    .element_count_o         (out_o.element_count),
    .amplitude_o             (out_o.amplitude),
    .mean_q8_o               (out_o.mean_q8),
    .std_dev_q8_o            (out_o.std_dev_q8),
    .disorder_q16_o          (out_o.disorder_q16),
    .repetition_count_o      (out_o.repetition_count),
    .duplicate_density_q16_o (out_o.duplicate_density_q16),
    .result_tag_o            (out_o.result_tag)
  );

endmodule
